// ===== hw/rtl/rhca_pkg.sv =====
package rhca_pkg;

   localparam logic [14:0] HUE_FULL  = 15'd23040;
   localparam logic [14:0] HUE_120   = 15'd7680;
   localparam logic [14:0] HUE_240   = 15'd15360;
   localparam logic [11:0] HUE_60    = 12'd3840;
   localparam logic [16:0] ONE_Q16   = 17'd65536;
   localparam logic [16:0] HALF_Q16  = 17'd32768;
   localparam int unsigned DIV_STEPS = 24;

   // register modes
   localparam logic [1:0] MODE_LIGHT = 2'd0;
   localparam logic [1:0] MODE_SAT   = 2'd1;
   localparam logic [1:0] MODE_HUE   = 2'd2;

   // register indexes
   localparam logic REG_MODE   = 1'b0;
   localparam logic REG_TARGET = 1'b1;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pix_type;

   typedef struct packed {
      logic [7:0]  alpha;
      logic [16:0] light;
      logic        gray;
   } side_type;

   // long division lane: upper 8 bits partial remainder, lower 24 dividend/quotient
   typedef struct packed {
      logic [31:0] work;
      logic [7:0]  den;
   } lane_type;

   typedef struct packed {
      side_type side;
      lane_type sat;
      lane_type hue;
   } div_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [16:0] tgt_ls;
      logic [14:0] tgt_hue;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [14:0] hue;
      logic [16:0] light;
      logic [16:0] sat;
   } px_out_type;

   function automatic lane_type div_step(lane_type ln);
      logic [8:0] r9;
      logic       q;
      lane_type   nx;
      r9 = ln.work[31:23];
      if (r9 >= {1'b0, ln.den}) begin
         r9 = r9 - {1'b0, ln.den};
         q  = 1'b1;
      end else begin
         q  = 1'b0;
      end
      nx.den  = ln.den;
      nx.work = {r9[7:0], ln.work[22:0], q};
      return nx;
   endfunction

endpackage

// ===== hw/rtl/rhca_analyze.sv =====
module rhca_analyze (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  rhca_pkg::pix_type in_px,
   output logic             out_valid,
   output rhca_pkg::div_type out_div
);
   import rhca_pkg::*;

   localparam logic [1:0] SEC_RED   = 2'd0;
   localparam logic [1:0] SEC_GREEN = 2'd1;
   localparam logic [1:0] SEC_BLUE  = 2'd2;
   localparam logic [24:0] RECIP_255 = 25'd16843010;

   logic       a_valid_ff;
   logic [8:0] a_sum_ff, a_sum_in;
   logic [7:0] a_delta_ff, a_delta_in;
   logic [1:0] a_sector_ff, a_sector_in;
   logic [7:0] a_x_ff, a_x_in;
   logic [7:0] a_y_ff, a_y_in;
   logic [7:0] a_alpha_ff;
   logic [7:0] mx, mn;

   logic       b_valid_ff;
   div_type    b_div_ff, b_div_in;
   logic [15:0] k;
   logic [25:0] total;
   logic [33:0] lprod;
   logic [8:0]  den9;

   always_comb begin
      mx = in_px.red;
      mn = in_px.red;
      if (in_px.green > mx) mx = in_px.green;
      if (in_px.blue > mx) mx = in_px.blue;
      if (in_px.green < mn) mn = in_px.green;
      if (in_px.blue < mn) mn = in_px.blue;
      a_sum_in   = {1'b0, mx} + {1'b0, mn};
      a_delta_in = mx - mn;
      if (mx == in_px.red) begin
         a_sector_in = SEC_RED;
         a_x_in      = in_px.green;
         a_y_in      = in_px.blue;
      end else if (mx == in_px.green) begin
         a_sector_in = SEC_GREEN;
         a_x_in      = in_px.blue;
         a_y_in      = in_px.red;
      end else begin
         a_sector_in = SEC_BLUE;
         a_x_in      = in_px.red;
         a_y_in      = in_px.green;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_sum_ff    <= a_sum_in;
         a_delta_ff  <= a_delta_in;
         a_sector_ff <= a_sector_in;
         a_x_ff      <= a_x_in;
         a_y_ff      <= a_y_in;
         a_alpha_ff  <= in_px.alpha;
      end
   end

   // full turn plus sector base, so the dividend stays non-negative
   always_comb begin
      case (a_sector_ff)
         SEC_RED:   k = 16'd23040;
         SEC_GREEN: k = 16'd30720;
         default:   k = 16'd38400;
      endcase
      total = 26'(k) * 26'(a_delta_ff) + 26'(HUE_60) * 26'(a_x_ff)
            - 26'(HUE_60) * 26'(a_y_ff);
      lprod = 34'(a_sum_ff) * 34'(RECIP_255);
      den9  = (a_sum_ff < 9'd255) ? a_sum_ff : 9'd510 - a_sum_ff;
      b_div_in.side.alpha = a_alpha_ff;
      b_div_in.side.light = lprod[33:17];
      b_div_in.side.gray  = (a_delta_ff == 8'd0);
      b_div_in.sat.work   = {8'd0, a_delta_ff, 16'd0};
      b_div_in.sat.den    = den9[7:0];
      b_div_in.hue.work   = {8'd0, total[23:0]};
      b_div_in.hue.den    = a_delta_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_div_ff <= b_div_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_div   = b_div_ff;

endmodule

// ===== hw/rtl/rhca_div.sv =====
module rhca_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  rhca_pkg::div_type in_div,
   output logic              out_valid,
   output rhca_pkg::div_type out_div
);
   import rhca_pkg::*;

   div_type stage_ff [DIV_STEPS];
   div_type stage_in [DIV_STEPS];
   logic    valid_ff [DIV_STEPS];

   // one quotient bit per stage for both lanes
   always_comb begin
      for (int i = 0; i < DIV_STEPS; i++) begin
         if (i == 0) begin
            stage_in[i].side = in_div.side;
            stage_in[i].sat  = div_step(in_div.sat);
            stage_in[i].hue  = div_step(in_div.hue);
         end else begin
            stage_in[i].side = stage_ff[i-1].side;
            stage_in[i].sat  = div_step(stage_ff[i-1].sat);
            stage_in[i].hue  = div_step(stage_ff[i-1].hue);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STEPS; i++) valid_ff[i] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < DIV_STEPS; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < DIV_STEPS; i++) stage_ff[i] <= stage_in[i];
      end
   end

   assign out_valid = valid_ff[DIV_STEPS-1];
   assign out_div   = stage_ff[DIV_STEPS-1];

endmodule

// ===== hw/rtl/rhca_synth.sv =====
module rhca_synth (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  rhca_pkg::cfg_type    cfg,
   input  logic                 in_valid,
   input  rhca_pkg::div_type    in_div,
   output logic                 out_valid,
   output rhca_pkg::px_out_type out_px
);
   import rhca_pkg::*;

   typedef struct packed {
      logic [7:0]  alpha;
      logic [14:0] hue;
      logic [16:0] light;
      logic [16:0] sat;
   } info_type;

   function automatic logic [11:0] ramp_weight(logic [14:0] h);
      logic [14:0] t;
      if (h < 15'(HUE_60)) t = h;
      else if (h < 15'd11520) t = 15'(HUE_60);
      else if (h < HUE_240) t = HUE_240 - h;
      else t = 15'd0;
      return t[11:0];
   endfunction

   // stage c: finish hls, apply replacement
   logic        c_valid_ff;
   info_type    c_info_ff, c_info_in;
   logic [16:0] c_l_ff, c_l_in;
   logic [16:0] c_s_ff, c_s_in;
   logic [14:0] c_h_ff, c_h_in;
   logic [15:0] qh;

   always_comb begin
      qh = in_div.hue.work[15:0];
      c_info_in.alpha = in_div.side.alpha;
      c_info_in.light = in_div.side.light;
      if (in_div.side.gray) begin
         c_info_in.hue = 15'd0;
         c_info_in.sat = 17'd0;
      end else begin
         c_info_in.hue = (qh >= 16'(HUE_FULL)) ? 15'(qh - 16'(HUE_FULL)) : qh[14:0];
         c_info_in.sat = in_div.sat.work[16:0];
      end
      c_l_in = c_info_in.light;
      c_s_in = c_info_in.sat;
      c_h_in = c_info_in.hue;
      case (cfg.mode)
         MODE_LIGHT: c_l_in = cfg.tgt_ls;
         MODE_SAT:   c_s_in = cfg.tgt_ls;
         MODE_HUE:   c_h_in = cfg.tgt_hue;
         default:    c_l_in = c_info_in.light;
      endcase
   end

   // stage d: v2
   logic        d_valid_ff;
   info_type    d_info_ff;
   logic [32:0] d_v2_ff, d_v2_in;
   logic [16:0] d_l_ff;
   logic [14:0] d_h_ff;
   logic        d_gray_ff;
   logic [7:0]  d_gval_ff, d_gval_in;
   logic [33:0] ls_prod;
   logic [33:0] v2_wide;
   logic [24:0] gprod;

   always_comb begin
      ls_prod = 34'(c_l_ff) * 34'(c_s_ff);
      if (c_l_ff < HALF_Q16) begin
         v2_wide = {1'b0, c_l_ff, 16'd0} + ls_prod;
      end else begin
         v2_wide = {1'b0, c_l_ff, 16'd0} + {1'b0, c_s_ff, 16'd0} - ls_prod;
      end
      d_v2_in   = v2_wide[32:0];
      gprod     = 25'(c_l_ff) * 25'd255;
      d_gval_in = gprod[23:16];
   end

   // stage e: v1, slope and per-channel ramp weights
   logic        e_valid_ff;
   info_type    e_info_ff;
   logic [32:0] e_v1_ff, e_v1_in;
   logic [32:0] e_diff_ff, e_diff_in;
   logic [11:0] e_w_ff [3];
   logic [11:0] e_w_in [3];
   logic        e_gray_ff;
   logic [7:0]  e_gval_ff;
   logic [33:0] v1_wide;
   logic [15:0] hr;
   logic [14:0] hb;

   always_comb begin
      v1_wide   = {d_l_ff, 17'd0} - {1'b0, d_v2_ff};
      e_v1_in   = v1_wide[32:0];
      e_diff_in = d_v2_ff - e_v1_in;
      hr        = {1'b0, d_h_ff} + {1'b0, HUE_120};
      if (hr >= {1'b0, HUE_FULL}) hr = hr - {1'b0, HUE_FULL};
      hb        = (d_h_ff >= HUE_120) ? d_h_ff - HUE_120 : d_h_ff + HUE_240;
      e_w_in[0] = ramp_weight(hr[14:0]);
      e_w_in[1] = ramp_weight(d_h_ff);
      e_w_in[2] = ramp_weight(hb);
   end

   // stage f: ramp numerators
   logic        f_valid_ff;
   info_type    f_info_ff;
   logic [43:0] f_num_ff [3];
   logic [43:0] f_num_in [3];
   logic        f_gray_ff;
   logic [7:0]  f_gval_ff;
   logic [44:0] num_wide [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         num_wide[c] = (45'(e_v1_ff) << 12) - (45'(e_v1_ff) << 8)
                     + 45'(e_diff_ff) * 45'(e_w_ff[c]);
         f_num_in[c] = num_wide[c][43:0];
      end
   end

   // stage g: scale by 255/3840 = 17/256 and take the integer part
   logic        g_valid_ff;
   px_out_type  g_px_ff, g_px_in;
   logic [47:0] sprod [3];
   logic [7:0]  ch [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sprod[c] = 48'(f_num_ff[c]) * 48'd17;
         ch[c]    = f_gray_ff ? f_gval_ff : sprod[c][47:40];
      end
      g_px_in.red   = ch[0];
      g_px_in.green = ch[1];
      g_px_in.blue  = ch[2];
      g_px_in.alpha = f_info_ff.alpha;
      g_px_in.hue   = f_info_ff.hue;
      g_px_in.light = f_info_ff.light;
      g_px_in.sat   = f_info_ff.sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= in_valid;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
         g_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_info_ff <= c_info_in;
         c_l_ff    <= c_l_in;
         c_s_ff    <= c_s_in;
         c_h_ff    <= c_h_in;

         d_info_ff <= c_info_ff;
         d_v2_ff   <= d_v2_in;
         d_l_ff    <= c_l_ff;
         d_h_ff    <= c_h_ff;
         d_gray_ff <= (c_s_ff == 17'd0);
         d_gval_ff <= d_gval_in;

         e_info_ff <= d_info_ff;
         e_v1_ff   <= e_v1_in;
         e_diff_ff <= e_diff_in;
         for (int c = 0; c < 3; c++) e_w_ff[c] <= e_w_in[c];
         e_gray_ff <= d_gray_ff;
         e_gval_ff <= d_gval_ff;

         f_info_ff <= e_info_ff;
         for (int c = 0; c < 3; c++) f_num_ff[c] <= f_num_in[c];
         f_gray_ff <= e_gray_ff;
         f_gval_ff <= e_gval_ff;

         g_px_ff   <= g_px_in;
      end
   end

   assign out_valid = g_valid_ff;
   assign out_px    = g_px_ff;

endmodule

// ===== hw/rtl/rgb_hls_component_adjust_unit.sv =====
// rgb to hls component adjust unit
// req channel: one rgba pixel per beat (valid/ready). rsp channel: one beat per
// pixel with the adjusted rgb, alpha copied through and the input pixel's hls
// (hue in 1/64 degree, lightness and saturation with 65536 = 1.0).
// csr port: apb-style, register 0 at byte 0 is the mode (0 lightness,
// 1 saturation, 2 hue, 3 none), register 1 at byte 4 is the target value.
// the req beat passes two analysis stages, 24 stages
// of the bit-per-stage divider shared by saturation and hue, and five stages for
// the back conversion and the output register.
// throughput: one pixel per cycle while rsp_ready is high.
// the whole pipeline advances together; when rsp holds a beat that is not
// taken, every stage holds and req_ready drops in the same cycle, so nothing
// is lost or repeated.
// reset clears all stage valid bits, sets mode to 0 and target to 32768.
// write the csr registers only while the pipeline is empty.
module rgb_hls_component_adjust_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic [7:0]  req_alpha_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic [7:0]  rsp_alpha_out,
   output logic [14:0] rsp_input_hue,
   output logic [16:0] rsp_input_lightness,
   output logic [16:0] rsp_input_saturation,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rhca_pkg::*;

   logic [1:0]  mode_ff;
   logic [16:0] target_ff;
   logic [16:0] tgt_ls_ff, tgt_ls_in;
   logic [14:0] tgt_hue_ff;
   logic [16:0] hue_mod_in;
   logic [16:0] wv;
   logic        csr_wr;
   logic        adv;
   pix_type     in_px;
   cfg_type     cfg;
   logic        ana_valid, div_valid;
   div_type     ana_div, div_out;
   px_out_type  out_px;

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   // clamp and hue reduction are done once, at the write
   always_comb begin
      wv         = csr_pwdata[16:0];
      tgt_ls_in  = (wv > ONE_Q16) ? ONE_Q16 : wv;
      if (wv >= 17'd115200) hue_mod_in = wv - 17'd115200;
      else if (wv >= 17'd92160) hue_mod_in = wv - 17'd92160;
      else if (wv >= 17'd69120) hue_mod_in = wv - 17'd69120;
      else if (wv >= 17'd46080) hue_mod_in = wv - 17'd46080;
      else if (wv >= 17'({2'b0, HUE_FULL})) hue_mod_in = wv - 17'({2'b0, HUE_FULL});
      else hue_mod_in = wv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_LIGHT;
         target_ff  <= HALF_Q16;
         tgt_ls_ff  <= HALF_Q16;
         tgt_hue_ff <= 15'd9728;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            REG_MODE: mode_ff <= csr_pwdata[1:0];
            REG_TARGET: begin
               target_ff  <= wv;
               tgt_ls_ff  <= tgt_ls_in;
               tgt_hue_ff <= hue_mod_in[14:0];
            end
            default: mode_ff <= mode_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_MODE:   csr_prdata = {30'd0, mode_ff};
         REG_TARGET: csr_prdata = {15'd0, target_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   assign cfg.mode    = mode_ff;
   assign cfg.tgt_ls  = tgt_ls_ff;
   assign cfg.tgt_hue = tgt_hue_ff;

   assign adv       = ~rsp_valid | rsp_ready;
   assign req_ready = adv;

   assign in_px.red   = req_red_in;
   assign in_px.green = req_green_in;
   assign in_px.blue  = req_blue_in;
   assign in_px.alpha = req_alpha_in;

   rhca_analyze u_analyze (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_px     (in_px),
      .out_valid (ana_valid),
      .out_div   (ana_div)
   );

   rhca_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (ana_valid),
      .in_div    (ana_div),
      .out_valid (div_valid),
      .out_div   (div_out)
   );

   rhca_synth u_synth (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg),
      .in_valid  (div_valid),
      .in_div    (div_out),
      .out_valid (rsp_valid),
      .out_px    (out_px)
   );

   assign rsp_red_out          = out_px.red;
   assign rsp_green_out        = out_px.green;
   assign rsp_blue_out         = out_px.blue;
   assign rsp_alpha_out        = out_px.alpha;
   assign rsp_input_hue        = out_px.hue;
   assign rsp_input_lightness  = out_px.light;
   assign rsp_input_saturation = out_px.sat;

endmodule

// ===== hw/rtl/rhca_checker.sv =====
module rhca_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_red_out,
   input logic [14:0] rsp_input_hue,
   input logic [16:0] rsp_input_lightness,
   input logic [16:0] rsp_input_saturation
);

   // a held rsp beat stays valid and keeps its red channel
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red_out))
      else $error("rsp beat changed while stalled");

   // pipeline freezes while output is blocked
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("req accepted while rsp stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   a_hls_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_input_hue < 15'd23040 && rsp_input_lightness <= 17'd65536
                    && rsp_input_saturation <= 17'd65536)
      else $error("input hls out of range");

endmodule

bind rgb_hls_component_adjust_unit rhca_checker u_rhca_checker (
   .clock                (clock),
   .reset                (reset),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_red_out          (rsp_red_out),
   .rsp_input_hue        (rsp_input_hue),
   .rsp_input_lightness  (rsp_input_lightness),
   .rsp_input_saturation (rsp_input_saturation)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import rhca_pkg::*;

   class pixel_scoreboard;
      px_out_type pending[$];
      logic [1:0]  mode;
      logic [16:0] target;
      int errors;
      int shown;

      function new();
         mode = MODE_LIGHT;
         target = 17'd32768;
         errors = 0;
         shown = 0;
      endfunction

      function logic [7:0] ramp(longint unsigned v1, longint unsigned v2,
                                longint unsigned h);
         longint unsigned num;
         if (h < 3840) num = v1 * 3840 + (v2 - v1) * h;
         else if (h < 3 * 3840) num = v2 * 3840;
         else if (h < 4 * 3840) num = v1 * 3840 + (v2 - v1) * (4 * 3840 - h);
         else num = v1 * 3840;
         return 8'(((num * 255) / 3840) >> 32);
      endfunction

      function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                               logic [7:0] a);
         longint unsigned mx, mn, sum, delta, l, s, h, bs, x, y, v1, v2, tgt;
         longint unsigned rr, gg, bb;
         px_out_type e;
         rr = 64'(r); gg = 64'(g); bb = 64'(b);
         mx = rr; mn = rr; s = 0; h = 0; tgt = 64'(target);
         if (gg > mx) mx = gg;
         if (bb > mx) mx = bb;
         if (gg < mn) mn = gg;
         if (bb < mn) mn = bb;
         sum = mx + mn;
         delta = mx - mn;
         l = sum * 32768 / 255;
         if (delta != 0) begin
            if (sum < 255) s = delta * 65536 / sum;
            else s = delta * 65536 / (510 - sum);
            if (mx == rr) begin bs = 0; x = gg; y = bb; end
            else if (mx == gg) begin bs = 7680; x = bb; y = rr; end
            else begin bs = 15360; x = rr; y = gg; end
            h = (((23040 + bs) * delta + 3840 * x - 3840 * y) / delta) % 23040;
         end
         e.hue = 15'(h); e.light = 17'(l); e.sat = 17'(s); e.alpha = a;
         if (mode == MODE_LIGHT) l = tgt > 65536 ? 65536 : tgt;
         else if (mode == MODE_SAT) s = tgt > 65536 ? 65536 : tgt;
         else if (mode == MODE_HUE) h = tgt % 23040;
         if (s == 0) begin
            e.red = 8'(l * 255 / 65536);
            e.green = e.red;
            e.blue = e.red;
         end else begin
            if (l < 32768) v2 = l * (65536 + s);
            else v2 = l * 65536 + s * 65536 - l * s;
            v1 = 2 * l * 65536 - v2;
            e.red = ramp(v1, v2, (h + 7680) % 23040);
            e.green = ramp(v1, v2, h);
            e.blue = ramp(v1, v2, (h + 23040 - 7680) % 23040);
         end
         pending.push_back(e);
      endfunction

      function void check_pixel(px_out_type got);
         px_out_type e;
         if (pending.size() == 0) begin
            errors++;
            if (shown < 10) begin
               shown++;
               $display("unexpected rsp beat %p", got);
            end
            return;
         end
         e = pending.pop_front();
         if (got !== e) begin
            errors++;
            if (shown < 10) begin
               shown++;
               $display("rsp mismatch: expected %p actual %p", e, got);
            end
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, rsp_ready = 0;
   logic [7:0] req_red_in = 0, req_green_in = 0, req_blue_in = 0, req_alpha_in = 0;
   logic req_ready, rsp_valid;
   logic [7:0] rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out;
   logic [14:0] rsp_input_hue;
   logic [16:0] rsp_input_lightness, rsp_input_saturation;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic csr_pready;
   int send_idle, recv_idle;
   pixel_scoreboard board;

   always #1 clock = ~clock;

   rgb_hls_component_adjust_unit dut (.*);

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

   // result side: random stall, check each beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_pixel({rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out,
                            rsp_input_hue, rsp_input_lightness, rsp_input_saturation});
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle);
   end

   task automatic write_reg(logic idx, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (idx == REG_MODE) board.mode = value[1:0];
      else board.target = value[16:0];
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // valid stays high across calls so beats can follow with no gap
   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             logic [7:0] a);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_red_in <= r; req_green_in <= g; req_blue_in <= b; req_alpha_in <= a;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_pixel(r, g, b, a);
   endtask

   task automatic random_pixels(int count);
      logic [7:0] r, g, b;
      for (int i = 0; i < count; i++) begin
         r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
         case ($urandom_range(5))
            0: g = r;
            1: begin g = r; b = r; end
            2: b = 8'd255 - r;
            default: ;
         endcase
         send_pixel(r, g, b, 8'($urandom));
      end
   endtask

   initial begin
      logic [16:0] targets[6];
      logic [7:0] corner[13][3];
      board = new();
      send_idle = 16; recv_idle = 71;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      corner = '{'{0, 0, 0}, '{255, 255, 255}, '{128, 128, 128}, '{255, 0, 0},
                 '{0, 255, 0}, '{0, 0, 255}, '{255, 255, 0}, '{0, 255, 255},
                 '{255, 0, 255}, '{255, 0, 1}, '{1, 0, 255}, '{127, 128, 0},
                 '{200, 100, 150}};
      // directed: reset settings, then each mode with extreme and mid-range targets
      for (int i = 0; i < 13; i++)
         send_pixel(corner[i][0], corner[i][1], corner[i][2], 8'(i));
      drain();
      targets = '{17'd0, 17'd65536, 17'd131071, 17'd23039, 17'd23040, 17'd12345};
      for (int m = 0; m < 4; m++) begin
         write_reg(REG_MODE, m);
         for (int t = 0; t < 6; t++) begin
            write_reg(REG_TARGET, targets[t]);
            for (int i = 0; i < 3; i++)
               send_pixel(corner[(t + i * 4) % 13][0], corner[(t + i * 4) % 13][1],
                          corner[(t + i * 4) % 13][2], 8'hff - 8'(t));
            drain();
         end
      end
      // random phases
      for (int p = 0; p < 12; p++) begin
         if (p == 4) begin send_idle = 71; recv_idle = 16; end
         if (p == 8) begin send_idle = 0; recv_idle = 0; end
         write_reg(REG_MODE, $urandom_range(3));
         write_reg(REG_TARGET, $urandom_range(3) == 0 ? $urandom : $urandom_range(65536));
         random_pixels(50);
         drain();
      end
      drain();
      if (board.errors == 0 && board.pending.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
